[design/twr_pkg.sv]
// twr_pkg: shared types and constants for the two-way ranging distance block.
// Request and result payload structs, pipeline control struct, status codes.
// No dependencies.
package twr_pkg;

  localparam int FIELD_W    = 40;
  localparam int DIST_W     = 24;
  localparam int MM_W       = 32;
  localparam int FRAC_BITS  = 8;
  localparam int QUO_LIM    = 56;
  localparam int SPLIT_W    = 28;
  localparam logic [MM_W-1:0] MM_RESET = 32'd78713660;
  localparam logic [QUO_LIM-1:0] POS_MAX = 56'd8388607;
  localparam logic [QUO_LIM-1:0] NEG_MAX = 56'd8388608;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEN_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } twr_status_t;

  typedef struct packed {
    logic [FIELD_W-1:0] poll_sent_time;
    logic [FIELD_W-1:0] poll_heard_time;
    logic [FIELD_W-1:0] reply_sent_time;
    logic [FIELD_W-1:0] reply_heard_time;
    logic [FIELD_W-1:0] final_sent_time;
    logic [FIELD_W-1:0] final_heard_time;
  } twr_req_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance_mm;
    twr_status_t              status;
  } twr_res_t;

  typedef struct packed {
    logic valid;
    logic neg;
    logic den_zero;
  } twr_ctl_t;

endpackage

[design/twr_time_of_flight_distance_top.sv]
// twr_time_of_flight_distance_top: double-sided two-way ranging distance block.
// Interval, product and numerator stages, a row of division cells, scaling.
// Depends on twr_pkg, twr_div_cell and twr_scale.
//
// Usage:
//   A request (six radio timestamps in in_req) is taken at each clock edge
//   where start is high; busy stays low, so one request may enter every cycle.
//   Each result appears on out_res for exactly one cycle with out_valid high,
//   in request order, after passing through the stages of the pipeline:
//   four front stages for intervals, split products, full products and numerator,
//   one division cell per quotient bit (2*STAMP_BITS+8 cells), three scale stages.
//   Throughput is one request per cycle; every stage is a register step.
//   The receiver cannot stall: results are presented once and not held.
//   cfg_we with cfg_wdata writes the millimetre-per-tick scale (Q8.24); write
//   it only while no request is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and restores the scale
//   register to its default of about 4.69 mm per tick.
//   Status: 0 ok, 1 zero denominator (distance 0), 2 distance saturated.
module twr_time_of_flight_distance_top #(
  parameter int STAMP_BITS = 40
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  twr_pkg::twr_req_t        in_req,
  output logic                     out_valid,
  output twr_pkg::twr_res_t        out_res,
  input  logic                     cfg_we,
  input  logic [twr_pkg::MM_W-1:0] cfg_wdata
);

  localparam int S     = STAMP_BITS;
  localparam int H     = (S + 1) / 2;
  localparam int L     = S - H;
  localparam int DEN_W = S + 2;
  localparam int PR_W  = 2 * S;
  localparam int Q     = PR_W + twr_pkg::FRAC_BITS;

  logic [twr_pkg::MM_W-1:0] mm_r;
  twr_pkg::twr_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r;

  logic [S-1:0] ps, ph, rs, rh, fs, fh;
  logic [S-1:0] ra_r, rb_r, da_r, db_r;
  logic [DEN_W-1:0] den_nxt, den1_r, den2_r, den3_r, den4_r;

  logic [2*H-1:0] r00_r, d00_r;
  logic [S-1:0]   r01_r, r10_r, d01_r, d10_r;
  logic [2*L-1:0] r11_r, d11_r;
  logic [PR_W-1:0] prod_r_r, prod_d_r;
  logic [Q-1:0]    num4_r;
  logic            neg_nxt;

  assign busy = 1'b0;

  // Scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_r <= twr_pkg::MM_RESET;
    end else if (cfg_we) begin
      mm_r <= cfg_wdata;
    end
  end

  // Take the low STAMP_BITS bits of each stamp
  assign ps = S'(64'(in_req.poll_sent_time));
  assign ph = S'(64'(in_req.poll_heard_time));
  assign rs = S'(64'(in_req.reply_sent_time));
  assign rh = S'(64'(in_req.reply_heard_time));
  assign fs = S'(64'(in_req.final_sent_time));
  assign fh = S'(64'(in_req.final_heard_time));

  assign den_nxt = DEN_W'(S'(rh - ps)) + DEN_W'(S'(fh - rs))
                 + DEN_W'(S'(fs - rh)) + DEN_W'(S'(rs - ph));

  // Advance front control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl1_r <= '{valid: start && !busy, neg: 1'b0, den_zero: (den_nxt == '0)};
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= '{valid: ctl3_r.valid, neg: neg_nxt, den_zero: ctl3_r.den_zero};
    end
  end

  // Form intervals modulo 2^STAMP_BITS
  always_ff @(posedge clk) begin
    ra_r   <= rh - ps;
    rb_r   <= fh - rs;
    da_r   <= fs - rh;
    db_r   <= rs - ph;
    den1_r <= den_nxt;
  end

  // Split products into half-width partials
  always_ff @(posedge clk) begin
    r00_r  <= (2*H)'(ra_r[H-1:0]) * (2*H)'(rb_r[H-1:0]);
    r01_r  <= S'(ra_r[H-1:0]) * S'(rb_r[S-1:H]);
    r10_r  <= S'(ra_r[S-1:H]) * S'(rb_r[H-1:0]);
    r11_r  <= (2*L)'(ra_r[S-1:H]) * (2*L)'(rb_r[S-1:H]);
    d00_r  <= (2*H)'(da_r[H-1:0]) * (2*H)'(db_r[H-1:0]);
    d01_r  <= S'(da_r[H-1:0]) * S'(db_r[S-1:H]);
    d10_r  <= S'(da_r[S-1:H]) * S'(db_r[H-1:0]);
    d11_r  <= (2*L)'(da_r[S-1:H]) * (2*L)'(db_r[S-1:H]);
    den2_r <= den1_r;
  end

  // Sum partials into full products
  always_ff @(posedge clk) begin
    prod_r_r <= PR_W'(r00_r) + ((PR_W'(r01_r) + PR_W'(r10_r)) << H)
              + (PR_W'(r11_r) << (2*H));
    prod_d_r <= PR_W'(d00_r) + ((PR_W'(d01_r) + PR_W'(d10_r)) << H)
              + (PR_W'(d11_r) << (2*H));
    den3_r   <= den2_r;
  end

  // Take numerator magnitude and sign, add the fraction bits
  assign neg_nxt = (prod_r_r < prod_d_r);

  always_ff @(posedge clk) begin
    num4_r <= {(neg_nxt ? prod_d_r - prod_r_r : prod_r_r - prod_d_r),
               {twr_pkg::FRAC_BITS{1'b0}}};
    den4_r <= den3_r;
  end

  // Row of division cells, one per quotient bit
  twr_pkg::twr_ctl_t ctl_c [0:Q];
  logic [DEN_W-1:0]  rem_c [0:Q];
  logic [DEN_W-1:0]  den_c [0:Q];
  logic [Q-1:0]      num_c [0:Q];
  logic [Q-1:0]      quo_c [0:Q];

  assign ctl_c[0] = ctl4_r;
  assign rem_c[0] = '0;
  assign den_c[0] = den4_r;
  assign num_c[0] = num4_r;
  assign quo_c[0] = '0;

  for (genvar k = 0; k < Q; k++) begin : g_cell
    twr_div_cell #(
      .DEN_W(DEN_W),
      .NUM_W(Q)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_c[k]),
      .rem_i (rem_c[k]),
      .num_i (num_c[k]),
      .quo_i (quo_c[k]),
      .den_i (den_c[k]),
      .ctl_o (ctl_c[k+1]),
      .rem_o (rem_c[k+1]),
      .num_o (num_c[k+1]),
      .quo_o (quo_c[k+1]),
      .den_o (den_c[k+1])
    );
  end

  // Scale to millimetres and saturate
  twr_scale #(
    .QUO_W(Q)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_c[Q]),
    .quo_i   (quo_c[Q]),
    .mm_i    (mm_r),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  // A zero-denominator result carries distance zero
  a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == twr_pkg::ST_DEN_ZERO) |-> (out_res.distance_mm == '0))
    else $error("zero denominator with nonzero distance");

  // A saturated result sits at one of the limits
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == twr_pkg::ST_SAT) |->
    (out_res.distance_mm == 24'sd8388607 || out_res.distance_mm == -24'sd8388608))
    else $error("saturated distance not at a limit");

  // A request enters the cell row once it has passed the front control registers ctl1_r to ctl4_r
  a_row_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 ctl_c[0].valid)
    else $error("request lost ahead of divider");

  // A denominator-zero flag never travels with a negative sign
  a_zero_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_c[Q].valid && ctl_c[Q].den_zero) |-> !ctl_c[Q].neg)
    else $error("zero denominator marked negative");

endmodule

[design/twr_div_cell.sv]
// twr_div_cell: one restoring-division step; a row of these forms the divider.
// Takes one numerator bit a cycle and hands remainder and quotient onwards.
// Depends on twr_pkg.
module twr_div_cell #(
  parameter int DEN_W = 42,
  parameter int NUM_W = 88
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  twr_pkg::twr_ctl_t     ctl_i,
  input  logic [DEN_W-1:0]      rem_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [NUM_W-1:0]      quo_i,
  input  logic [DEN_W-1:0]      den_i,
  output twr_pkg::twr_ctl_t     ctl_o,
  output logic [DEN_W-1:0]      rem_o,
  output logic [NUM_W-1:0]      num_o,
  output logic [NUM_W-1:0]      quo_o,
  output logic [DEN_W-1:0]      den_o
);

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  // Bring down the next numerator bit and trial-subtract the divisor
  always_comb begin
    trial   = {rem_i, num_i[NUM_W-1]};
    diff    = trial - {1'b0, den_i};
    ge      = (trial >= {1'b0, den_i});
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // Advance control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    rem_o <= rem_nxt;
    num_o <= {num_i[NUM_W-2:0], 1'b0};
    quo_o <= {quo_i[NUM_W-2:0], ge};
    den_o <= den_i;
  end

endmodule

[design/twr_scale.sv]
// twr_scale: scales the tick quotient to millimetres and saturates to 24 bits.
// Three stages: split multiply, partial sum, saturate and sign.
// Depends on twr_pkg.
module twr_scale #(
  parameter int QUO_W = 88
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  twr_pkg::twr_ctl_t           ctl_i,
  input  logic [QUO_W-1:0]            quo_i,
  input  logic [twr_pkg::MM_W-1:0]    mm_i,
  output logic                        valid_o,
  output twr_pkg::twr_res_t           res_o
);

  localparam int PW = twr_pkg::SPLIT_W + twr_pkg::MM_W;
  localparam int SW = 2 * twr_pkg::SPLIT_W + twr_pkg::MM_W;

  twr_pkg::twr_ctl_t           ctl_a_r, ctl_b_r;
  logic                        big_a_r, big_b_r;
  logic [PW-1:0]               p0_r, p1_r;
  logic [twr_pkg::QUO_LIM-1:0] mag_r;
  logic [SW-1:0]               sum;
  logic                        sat;
  twr_pkg::twr_res_t           res_nxt;

  // Hold control through the scaling stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      valid_o <= 1'b0;
    end else begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
      valid_o <= ctl_b_r.valid;
    end
  end

  // Split multiply of the quotient by the scale
  always_ff @(posedge clk) begin
    big_a_r <= (|quo_i[QUO_W-1:twr_pkg::QUO_LIM]) && (mm_i != '0);
    p0_r    <= PW'(quo_i[twr_pkg::SPLIT_W-1:0]) * PW'(mm_i);
    p1_r    <= PW'(quo_i[twr_pkg::QUO_LIM-1:twr_pkg::SPLIT_W]) * PW'(mm_i);
  end

  // Combine partial products and drop the 32 fraction bits
  assign sum = SW'(p0_r) + (SW'(p1_r) << twr_pkg::SPLIT_W);

  always_ff @(posedge clk) begin
    big_b_r <= big_a_r;
    mag_r   <= sum[SW-1:twr_pkg::MM_W];
  end

  // Saturate and apply sign
  always_comb begin
    res_nxt = '0;
    sat     = 1'b0;
    if (ctl_b_r.den_zero) begin
      res_nxt.status = twr_pkg::ST_DEN_ZERO;
    end else if (ctl_b_r.neg) begin
      sat = big_b_r || (mag_r > twr_pkg::NEG_MAX);
      res_nxt.distance_mm = sat ? -24'sd8388608
                                : $signed(24'd0 - mag_r[twr_pkg::DIST_W-1:0]);
      res_nxt.status = sat ? twr_pkg::ST_SAT : twr_pkg::ST_OK;
    end else begin
      sat = big_b_r || (mag_r > twr_pkg::POS_MAX);
      res_nxt.distance_mm = sat ? 24'sd8388607 : $signed(mag_r[twr_pkg::DIST_W-1:0]);
      res_nxt.status = sat ? twr_pkg::ST_SAT : twr_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    res_o <= res_nxt;
  end

endmodule
